// File: rtl/gcsc_pkg.sv
// gcsc_pkg: shared constants, stream field layout, sequencer states and
// datapath control struct for the gated causal short convolution block.
// No dependencies.
`timescale 1ns / 1ps

package gcsc_pkg;

    // fixed field widths of the stream items
    localparam int DATA_W    = 16;
    localparam int FRAC_BITS = 12;
    localparam int CH_W      = 10;
    localparam int TAP_W     = 2;

    // parameter defaults
    localparam int CHANNELS_DEF = 1024;
    localparam int TAPS_DEF     = 3;

    // command codes carried in tuser
    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_LOAD   = 1'b1;

    // input tdata layout, lowest bit first
    localparam int IN_CH_LSB    = 0;
    localparam int IN_FIRST_LSB = IN_CH_LSB + CH_W;
    localparam int IN_TAP_LSB   = IN_FIRST_LSB + 1;
    localparam int IN_B_LSB     = IN_TAP_LSB + TAP_W;
    localparam int IN_C_LSB     = IN_B_LSB + DATA_W;
    localparam int IN_X_LSB     = IN_C_LSB + DATA_W;
    localparam int IN_W_LSB     = IN_X_LSB + DATA_W;
    localparam int IN_USED_W    = IN_W_LSB + DATA_W;
    localparam int IN_TDATA_W   = ((IN_USED_W + 7) / 8) * 8;

    // output tdata layout
    localparam int OUT_CH_LSB   = 0;
    localparam int OUT_Y_LSB    = OUT_CH_LSB + CH_W;
    localparam int OUT_USED_W   = OUT_Y_LSB + DATA_W;
    localparam int OUT_TDATA_W  = ((OUT_USED_W + 7) / 8) * 8;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_PROD,
        S_WIN,
        S_MAC,
        S_DRAIN,
        S_GATE,
        S_OUT
    } t_state;

    typedef struct packed {
        logic ld_prod;
        logic ld_win;
        logic mac_step;
        logic mac_drain;
        logic ld_gate;
    } t_mac_ctl;

endpackage

// File: rtl/gcsc_wmem.sv
// gcsc_wmem: weight memory, one row of TAPS weights per channel,
// single-lane writes and registered full-row reads. Uses gcsc_pkg.
`timescale 1ns / 1ps

module gcsc_wmem #(
    parameter int  CHANNELS = gcsc_pkg::CHANNELS_DEF,
    parameter int  TAPS     = gcsc_pkg::TAPS_DEF,
    localparam int AW       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
    input  logic                                  i_clk,
    input  logic                                  i_wr_en,
    input  logic [AW-1:0]                         i_wr_addr,
    input  logic [gcsc_pkg::TAP_W-1:0]            i_wr_lane,
    input  logic [gcsc_pkg::DATA_W-1:0]           i_wr_data,
    input  logic                                  i_rd_en,
    input  logic [AW-1:0]                         i_rd_addr,
    output logic [TAPS*gcsc_pkg::DATA_W-1:0]      o_rd_row
);

    localparam int DW = gcsc_pkg::DATA_W;

    logic [TAPS*DW-1:0] r_mem [CHANNELS];
    logic [TAPS*DW-1:0] r_rd_row;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr][i_wr_lane*DW +: DW] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_row <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_row = r_rd_row;

endmodule

// File: rtl/gcsc_hmem.sv
// gcsc_hmem: product history memory, one row of TAPS-1 products per channel,
// with a zeroing sweep after reset. Uses gcsc_pkg.
`timescale 1ns / 1ps

module gcsc_hmem #(
    parameter int  CHANNELS = gcsc_pkg::CHANNELS_DEF,
    parameter int  TAPS     = gcsc_pkg::TAPS_DEF,
    localparam int AW       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_rd_en,
    input  logic [AW-1:0]                         i_rd_addr,
    output logic [(TAPS-1)*gcsc_pkg::DATA_W-1:0]  o_rd_row,
    input  logic                                  i_wr_en,
    input  logic [AW-1:0]                         i_wr_addr,
    input  logic [(TAPS-1)*gcsc_pkg::DATA_W-1:0]  i_wr_row,
    output logic                                  o_clr_busy
);

    localparam int RW = (TAPS - 1) * gcsc_pkg::DATA_W;

    logic [RW-1:0] r_mem [CHANNELS];
    logic [RW-1:0] r_rd_row;
    logic [AW-1:0] r_clr_cnt;
    logic [AW-1:0] n_clr_cnt;
    logic          r_clr_busy;
    logic          n_clr_busy;

    always_comb begin
        n_clr_cnt  = r_clr_cnt;
        n_clr_busy = r_clr_busy;
        if (r_clr_busy) begin
            n_clr_cnt = r_clr_cnt + AW'(1);
            if (r_clr_cnt == AW'(CHANNELS - 1)) begin
                n_clr_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_cnt  <= '0;
            r_clr_busy <= 1'b1;
        end else begin
            r_clr_cnt  <= n_clr_cnt;
            r_clr_busy <= n_clr_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            r_mem[r_clr_cnt] <= '0;
        end else if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_row <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_row   = r_rd_row;
    assign o_clr_busy = r_clr_busy;

endmodule

// File: rtl/gcsc_mac.sv
// gcsc_mac: gated product, tap window, shared multiply-accumulate over the taps,
// output gate with rounding and saturation. Uses gcsc_pkg.
`timescale 1ns / 1ps

module gcsc_mac #(
    parameter int TAPS = gcsc_pkg::TAPS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  gcsc_pkg::t_mac_ctl                    i_ctl,
    input  logic                                  i_first,
    input  logic signed [gcsc_pkg::DATA_W-1:0]    i_b,
    input  logic signed [gcsc_pkg::DATA_W-1:0]    i_c,
    input  logic signed [gcsc_pkg::DATA_W-1:0]    i_x,
    input  logic [(TAPS-1)*gcsc_pkg::DATA_W-1:0]  i_hist_row,
    input  logic [TAPS*gcsc_pkg::DATA_W-1:0]      i_w_row,
    output logic [(TAPS-1)*gcsc_pkg::DATA_W-1:0]  o_hist_row,
    output logic                                  o_mac_last,
    output logic signed [gcsc_pkg::DATA_W-1:0]    o_y
);

    localparam int DW    = gcsc_pkg::DATA_W;
    localparam int FB    = gcsc_pkg::FRAC_BITS;
    localparam int PW    = 2 * DW;
    localparam int IDX_W = $clog2(TAPS);
    localparam int ACC_W = PW + $clog2(TAPS);
    localparam int G_W   = ACC_W + DW;
    localparam int PS_W  = PW + 1 - FB;
    localparam int YS_W  = G_W + 1 - 2 * FB;

    logic signed [PW-1:0]    r_bx;
    logic signed [PW:0]      p_sum;
    logic [PS_W-1:0]         p_sh;
    logic [PS_W-DW:0]        p_hi;
    logic signed [DW-1:0]    p_sat;

    logic signed [DW-1:0]    win [TAPS];
    logic signed [DW-1:0]    w_lane [TAPS];
    logic signed [DW-1:0]    r_win [TAPS];
    logic [IDX_W-1:0]        r_idx;
    logic signed [PW-1:0]    r_mp;
    logic                    r_mv;
    logic signed [ACC_W-1:0] r_acc;
    logic signed [G_W-1:0]   r_g;
    logic signed [G_W:0]     g_sum;
    logic [YS_W-1:0]         y_sh;
    logic [YS_W-DW:0]        y_hi;

    // gated product, round half up then saturate
    assign p_sum = {r_bx[PW-1], r_bx} + (PW + 1)'(1 << (FB - 1));
    assign p_sh  = p_sum[PW:FB];
    assign p_hi  = p_sh[PS_W-1:DW-1];
    assign p_sat = ((&p_hi) || !(|p_hi)) ? p_sh[DW-1:0]
                 : {p_sh[PS_W-1], {(DW-1){~p_sh[PS_W-1]}}};

    // window: stored history (or zeros on a first step), newest product last
    genvar gi;
    generate
        for (gi = 0; gi < TAPS - 1; gi++) begin : g_win
            assign win[gi] = i_first ? '0 : i_hist_row[gi*DW +: DW];
        end
        for (gi = 0; gi < TAPS; gi++) begin : g_wl
            assign w_lane[gi] = i_w_row[gi*DW +: DW];
        end
        for (gi = 0; gi < TAPS - 1; gi++) begin : g_hn
            assign o_hist_row[gi*DW +: DW] = win[gi+1];
        end
    endgenerate
    assign win[TAPS-1] = p_sat;

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld_prod) begin
            r_bx <= i_b * i_x;
        end
        if (i_ctl.ld_win) begin
            r_win <= win;
        end
        if (i_ctl.mac_step) begin
            r_mp <= r_win[r_idx] * w_lane[r_idx];
        end
        if (i_ctl.ld_win) begin
            r_acc <= '0;
        end else if ((i_ctl.mac_step || i_ctl.mac_drain) && r_mv) begin
            r_acc <= r_acc + ACC_W'(r_mp);
        end
        if (i_ctl.ld_gate) begin
            r_g <= r_acc * i_c;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
            r_mv  <= 1'b0;
        end else begin
            if (i_ctl.ld_win) begin
                r_idx <= '0;
                r_mv  <= 1'b0;
            end else if (i_ctl.mac_step) begin
                r_idx <= r_idx + IDX_W'(1);
                r_mv  <= 1'b1;
            end else if (i_ctl.mac_drain) begin
                r_mv  <= 1'b0;
            end
        end
    end

    assign o_mac_last = (r_idx == IDX_W'(TAPS - 1));

    // output gate, round half up then saturate
    assign g_sum = {r_g[G_W-1], r_g} + (G_W + 1)'(1 << (2 * FB - 1));
    assign y_sh  = g_sum[G_W:2*FB];
    assign y_hi  = y_sh[YS_W-1:DW-1];
    assign o_y   = ((&y_hi) || !(|y_hi)) ? y_sh[DW-1:0]
                 : {y_sh[YS_W-1], {(DW-1){~y_sh[YS_W-1]}}};

    a_win_restarts_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.ld_win |=> (r_idx == '0) && !r_mv)
        else $error("tap index not restarted after window load");

    a_step_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.mac_step |-> (r_idx <= IDX_W'(TAPS - 1)))
        else $error("tap index past last tap");

endmodule

// File: rtl/gated_causal_short_conv_top.sv
// gated_causal_short_conv_top: stream ports, input capture, sequencer and
// output register around the weight and history memories and the datapath.
// Uses gcsc_pkg, gcsc_wmem, gcsc_hmem, gcsc_mac.
//
//   port group   dir  contents
//   i_s_*        in   command and sample/weight item (tuser = cmd)
//   o_m_*        out  one result item per in-range sample
//
// a weight load is written as it is accepted; a sample steps through product,
// window, tap, drain, gate and output states, the single shared multiplier
// stepping through the taps after the row reads. after reset the history
// memory is zeroed one row a cycle, with i_s_tready low. a finished result
// sits in the output register, and the next item is taken while it waits;
// the block holds in its last step only when a new result finds it still full.
`timescale 1ns / 1ps

module gated_causal_short_conv_top #(
    parameter int CHANNELS = gcsc_pkg::CHANNELS_DEF,
    parameter int TAPS     = gcsc_pkg::TAPS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_s_tvalid,
    output logic                                  o_s_tready,
    // channel, first_step, tap, b_val, c_val, x_val, weight_val, zero pad
    input  logic [gcsc_pkg::IN_TDATA_W-1:0]       i_s_tdata,
    // cmd
    input  logic                                  i_s_tuser,
    output logic                                  o_m_tvalid,
    input  logic                                  i_m_tready,
    // out_channel, y_val, zero pad
    output logic [gcsc_pkg::OUT_TDATA_W-1:0]      o_m_tdata
);

    localparam int DW = gcsc_pkg::DATA_W;
    localparam int CW = gcsc_pkg::CH_W;
    localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    gcsc_pkg::t_state   r_state;
    gcsc_pkg::t_state   n_state;
    gcsc_pkg::t_mac_ctl mac_ctl;

    logic                     accept;
    logic [CW-1:0]            in_ch;
    logic                     in_first;
    logic [gcsc_pkg::TAP_W-1:0] in_tap;
    logic                     ch_ok;
    logic                     tap_ok;
    logic                     wt_wr;
    logic                     start;

    logic [CW-1:0]            r_ch;
    logic                     r_first;
    logic signed [DW-1:0]     r_b;
    logic signed [DW-1:0]     r_c;
    logic signed [DW-1:0]     r_x;

    logic [TAPS*DW-1:0]       w_row;
    logic [(TAPS-1)*DW-1:0]   h_row;
    logic [(TAPS-1)*DW-1:0]   h_new;
    logic                     h_wr;
    logic                     clr_busy;
    logic                     mac_last;
    logic signed [DW-1:0]     y;

    logic                     r_out_valid;
    logic [CW-1:0]            r_out_ch;
    logic [DW-1:0]            r_out_y;
    logic                     out_free;
    logic                     out_load;

    assign in_ch    = i_s_tdata[gcsc_pkg::IN_CH_LSB +: CW];
    assign in_first = i_s_tdata[gcsc_pkg::IN_FIRST_LSB];
    assign in_tap   = i_s_tdata[gcsc_pkg::IN_TAP_LSB +: gcsc_pkg::TAP_W];
    assign ch_ok    = (32'(in_ch) < CHANNELS);
    assign tap_ok   = (32'(in_tap) < TAPS);
    assign accept   = i_s_tvalid && o_s_tready;
    assign wt_wr    = accept && (i_s_tuser == gcsc_pkg::CMD_LOAD) && ch_ok && tap_ok;
    assign start    = accept && (i_s_tuser == gcsc_pkg::CMD_SAMPLE) && ch_ok;
    assign out_free = !r_out_valid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (start) begin
            r_ch    <= in_ch;
            r_first <= in_first;
            r_b     <= i_s_tdata[gcsc_pkg::IN_B_LSB +: DW];
            r_c     <= i_s_tdata[gcsc_pkg::IN_C_LSB +: DW];
            r_x     <= i_s_tdata[gcsc_pkg::IN_X_LSB +: DW];
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            gcsc_pkg::S_CLEAR: if (!clr_busy) n_state = gcsc_pkg::S_IDLE;
            gcsc_pkg::S_IDLE:  if (start) n_state = gcsc_pkg::S_PROD;
            gcsc_pkg::S_PROD:  n_state = gcsc_pkg::S_WIN;
            gcsc_pkg::S_WIN:   n_state = gcsc_pkg::S_MAC;
            gcsc_pkg::S_MAC:   if (mac_last) n_state = gcsc_pkg::S_DRAIN;
            gcsc_pkg::S_DRAIN: n_state = gcsc_pkg::S_GATE;
            gcsc_pkg::S_GATE:  n_state = gcsc_pkg::S_OUT;
            gcsc_pkg::S_OUT:   if (out_free) n_state = gcsc_pkg::S_IDLE;
            default:           n_state = gcsc_pkg::S_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_s_tready = 1'b0;
        mac_ctl    = '0;
        h_wr       = 1'b0;
        out_load   = 1'b0;
        unique case (r_state)
            gcsc_pkg::S_IDLE:  o_s_tready = 1'b1;
            gcsc_pkg::S_PROD:  mac_ctl.ld_prod = 1'b1;
            gcsc_pkg::S_WIN: begin
                mac_ctl.ld_win = 1'b1;
                h_wr           = 1'b1;
            end
            gcsc_pkg::S_MAC:   mac_ctl.mac_step = 1'b1;
            gcsc_pkg::S_DRAIN: mac_ctl.mac_drain = 1'b1;
            gcsc_pkg::S_GATE:  mac_ctl.ld_gate = 1'b1;
            gcsc_pkg::S_OUT:   out_load = out_free;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= gcsc_pkg::S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_ch <= r_ch;
            r_out_y  <= y;
        end
    end

    gcsc_wmem #(
        .CHANNELS (CHANNELS),
        .TAPS     (TAPS)
    ) u_wmem (
        .i_clk     (i_clk),
        .i_wr_en   (wt_wr),
        .i_wr_addr (AW'(in_ch)),
        .i_wr_lane (in_tap),
        .i_wr_data (i_s_tdata[gcsc_pkg::IN_W_LSB +: DW]),
        .i_rd_en   (start),
        .i_rd_addr (AW'(in_ch)),
        .o_rd_row  (w_row)
    );

    gcsc_hmem #(
        .CHANNELS (CHANNELS),
        .TAPS     (TAPS)
    ) u_hmem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_en    (start),
        .i_rd_addr  (AW'(in_ch)),
        .o_rd_row   (h_row),
        .i_wr_en    (h_wr),
        .i_wr_addr  (AW'(r_ch)),
        .i_wr_row   (h_new),
        .o_clr_busy (clr_busy)
    );

    gcsc_mac #(
        .TAPS (TAPS)
    ) u_mac (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (mac_ctl),
        .i_first    (r_first),
        .i_b        (r_b),
        .i_c        (r_c),
        .i_x        (r_x),
        .i_hist_row (h_row),
        .i_w_row    (w_row),
        .o_hist_row (h_new),
        .o_mac_last (mac_last),
        .o_y        (y)
    );

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(gcsc_pkg::OUT_TDATA_W - gcsc_pkg::OUT_USED_W){1'b0}},
                         r_out_y, r_out_ch};

    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        clr_busy |-> !o_s_tready)
        else $error("item taken while history is being cleared");

    a_hist_wr_after_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        h_wr |-> !clr_busy)
        else $error("history write during clearing sweep");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == gcsc_pkg::S_OUT && r_out_valid && !i_m_tready)
        |=> (r_state == gcsc_pkg::S_OUT))
        else $error("result dropped while output register full");

    a_start_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |=> (r_state == gcsc_pkg::S_PROD))
        else $error("sample start did not enter product step");

endmodule
